// ===== sv/mes_pkg.sv =====
// memory error statistics: shared types, event codes and constants
// used by mes_prep and memory_error_statistics_unit; no dependencies
package mes_pkg;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ADDR   = 2'd1,
    KIND_ECC    = 2'd2,
    KIND_PARITY = 2'd3
  } kind_t;

  localparam int          DefDataWidth  = 32;
  localparam int          DefErrorLimit = 65535;

  localparam logic [3:0]  WIDE_STRIDE_TEST = 4'd7;
  localparam logic [3:0]  STRIDE_WIDE      = 4'd8;
  localparam logic [3:0]  STRIDE_NARROW    = 4'd4;
  localparam logic [19:0] PAGE_MAX         = 20'hFFFFF;
  localparam logic [11:0] OFFSET_MAX       = 12'hFFF;
  localparam logic [15:0] CORR_MAX         = 16'hFFFF;
  localparam logic [20:0] SUM_MAX          = 21'h1FFFFF;
  localparam logic [5:0]  BITS_RESET_MIN   = 6'd32;

  // event after decode, state-independent part
  typedef struct packed {
    kind_t       kind;
    logic [31:0] addr;
    logic [19:0] page;
    logic [11:0] offset;
    logic [31:0] pattern;
    logic [5:0]  nbits;
    logic [3:0]  stride;
    logic        corrected;
  } prep_t;

  // ones count of a 32-bit word, nibble at a time
  function automatic logic [5:0] popcount32(input logic [31:0] x);
    logic [5:0] acc;
    logic [2:0] nib;
    acc = 6'd0;
    for (int i = 0; i < 8; i++) begin
      nib = 3'(x[4*i]) + 3'(x[4*i+1]) + 3'(x[4*i+2]) + 3'(x[4*i+3]);
      acc = acc + 6'(nib);
    end
    return acc;
  endfunction

endpackage

// ===== sv/mes_prep.sv =====
// memory error statistics: event decode ahead of the input register
// page/offset split, pattern select and mask, bit count; uses mes_pkg
module mes_prep
  import mes_pkg::*;
#(
  parameter int DATA_WIDTH = DefDataWidth
) (
  input  logic [1:0]  kind,
  input  logic [31:0] word_address,
  input  logic [31:0] expected,
  input  logic [31:0] observed,
  input  logic [31:0] error_bits,
  input  logic [3:0]  test_index,
  output prep_t       prep
);

  localparam logic [31:0] PatMask =
    (DATA_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << DATA_WIDTH) - 64'd1);

  logic [31:0] pat_raw;
  logic [31:0] pat;

  always_comb begin
    pat_raw = (kind_t'(kind) == KIND_ADDR) ? (expected ^ observed) : error_bits;
    pat     = pat_raw & PatMask;

    prep.kind      = kind_t'(kind);
    prep.addr      = word_address;
    prep.pattern   = pat;
    prep.nbits     = popcount32(pat);
    prep.stride    = (test_index == WIDE_STRIDE_TEST) ? STRIDE_WIDE : STRIDE_NARROW;
    prep.corrected = (observed != 32'd0);

    if (kind_t'(kind) == KIND_ECC) begin
      // wide ecc page and offset clamp to field range
      prep.page   = (word_address > 32'(PAGE_MAX)) ? PAGE_MAX : word_address[19:0];
      prep.offset = (expected > 32'(OFFSET_MAX)) ? OFFSET_MAX : expected[11:0];
    end else begin
      prep.page   = word_address[31:12];
      prep.offset = word_address[11:0];
    end
  end

endmodule

// ===== sv/memory_error_statistics_unit.sv =====
// memory error statistics, summary mode: top level
// input register, statistics update and result register; uses mes_pkg, mes_prep
//
// Usage:
//   in_* carries one memory error event per beat (kind, address, expected,
//   observed, error bits, test index). Each event yields exactly one result
//   beat on out_*: a changed flag and every running statistic after the
//   event has been folded in.
//   On the way from input beat to result beat, the event is decoded
//   (page/offset, pattern, bit count) into an input register, then compared
//   against the statistics registers, which update as the result register
//   loads. Throughput is one event per cycle while out_stall is low; the
//   single update stage holds the whole read-modify-write of the statistics.
//   When out_stall is high with a result waiting, the result holds, one more
//   event waits in the input register, and in_stall rises after that.
//   Synchronous reset (rst_n low) empties both registers and returns the
//   statistics to their initial values: lowest page/offset all ones,
//   fewest bits 32, run length 1, everything else zero.
module memory_error_statistics_unit
  import mes_pkg::*;
#(
  parameter int DATA_WIDTH  = DefDataWidth,
  parameter int ERROR_LIMIT = DefErrorLimit
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_word_address,
  input  logic [31:0] in_expected,
  input  logic [31:0] in_observed,
  input  logic [31:0] in_error_bits,
  input  logic [3:0]  in_test_index,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_changed,
  output logic [15:0] out_total_errors,
  output logic [15:0] out_corrected_count,
  output logic [19:0] out_lowest_page,
  output logic [11:0] out_lowest_offset,
  output logic [19:0] out_highest_page,
  output logic [11:0] out_highest_offset,
  output logic [31:0] out_failing_mask,
  output logic [20:0] out_bits_total,
  output logic [5:0]  out_fewest_bits,
  output logic [5:0]  out_most_bits,
  output logic [15:0] out_longest_run
);

  localparam logic [15:0] Limit = 16'(ERROR_LIMIT);

  prep_t prep;
  prep_t ev_r;
  logic  ev_valid_r;
  logic  out_valid_r;
  logic  adv;
  logic  fire;
  logic  in_fire;

  // statistics
  logic [15:0] cnt_r,      cnt_nxt;
  logic [15:0] corr_r,     corr_nxt;
  logic [19:0] lo_page_r,  lo_page_nxt;
  logic [11:0] lo_off_r,   lo_off_nxt;
  logic [19:0] hi_page_r,  hi_page_nxt;
  logic [11:0] hi_off_r,   hi_off_nxt;
  logic [31:0] mask_r,     mask_nxt;
  logic [20:0] sum_r,      sum_nxt;
  logic [5:0]  fewest_r,   fewest_nxt;
  logic [5:0]  most_r,     most_nxt;
  logic [15:0] run_r,      run_nxt;
  logic [15:0] max_run_r,  max_run_nxt;
  logic [31:0] last_r,     last_nxt;
  logic        changed_nxt;

  // result register payload
  logic        res_changed_r;
  logic [15:0] res_cnt_r;
  logic [15:0] res_corr_r;
  logic [19:0] res_lo_page_r;
  logic [11:0] res_lo_off_r;
  logic [19:0] res_hi_page_r;
  logic [11:0] res_hi_off_r;
  logic [31:0] res_mask_r;
  logic [20:0] res_sum_r;
  logic [5:0]  res_fewest_r;
  logic [5:0]  res_most_r;
  logic [15:0] res_max_run_r;

  logic [21:0] sum_wide;
  logic        adjacent;

  mes_prep #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_prep (
    .kind         (in_kind),
    .word_address (in_word_address),
    .expected     (in_expected),
    .observed     (in_observed),
    .error_bits   (in_error_bits),
    .test_index   (in_test_index),
    .prep         (prep)
  );

  assign adv      = !out_valid_r || !out_stall;
  assign fire     = ev_valid_r && adv;
  assign in_stall = ev_valid_r && !adv;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    cnt_nxt      = (cnt_r < Limit) ? cnt_r + 16'd1 : cnt_r;
    corr_nxt     = corr_r;
    lo_page_nxt  = lo_page_r;
    lo_off_nxt   = lo_off_r;
    hi_page_nxt  = hi_page_r;
    hi_off_nxt   = hi_off_r;
    mask_nxt     = mask_r;
    sum_nxt      = sum_r;
    fewest_nxt   = fewest_r;
    most_nxt     = most_r;
    run_nxt      = run_r;
    max_run_nxt  = max_run_r;
    last_nxt     = last_r;
    changed_nxt  = 1'b0;
    sum_wide     = 22'(sum_r) + 22'(ev_r.nbits);
    adjacent     = (ev_r.addr == last_r + 32'(ev_r.stride)) ||
                   (ev_r.addr == last_r - 32'(ev_r.stride));

    if (ev_r.kind != KIND_PARITY) begin
      if (ev_r.kind == KIND_ECC && ev_r.corrected && corr_r != CORR_MAX) begin
        corr_nxt = corr_r + 16'd1;
      end
      if (ev_r.page < lo_page_r) begin
        lo_page_nxt = ev_r.page;
        changed_nxt = 1'b1;
      end
      if (ev_r.offset < lo_off_r) begin
        lo_off_nxt  = ev_r.offset;
        changed_nxt = 1'b1;
      end
      if (ev_r.page > hi_page_r) begin
        hi_page_nxt = ev_r.page;
        changed_nxt = 1'b1;
      end
      if (ev_r.offset > hi_off_r) begin
        hi_off_nxt  = ev_r.offset;
        changed_nxt = 1'b1;
      end
      // total only grows while the count is short of the limit
      if (cnt_nxt < Limit) begin
        sum_nxt = sum_wide[21] ? SUM_MAX : sum_wide[20:0];
      end
      if (ev_r.nbits > most_r) begin
        most_nxt    = ev_r.nbits;
        changed_nxt = 1'b1;
      end
      if (ev_r.nbits < fewest_r) begin
        fewest_nxt  = ev_r.nbits;
        changed_nxt = 1'b1;
      end
      // flag on any difference, even with no new bit
      if ((mask_r ^ ev_r.pattern) != 32'd0) begin
        changed_nxt = 1'b1;
      end
      mask_nxt = mask_r | ev_r.pattern;
      if (adjacent) begin
        run_nxt = (run_r < Limit) ? run_r + 16'd1 : run_r;
      end else begin
        run_nxt = 16'd1;
      end
      if (run_nxt > max_run_r) begin
        max_run_nxt = run_nxt;
        changed_nxt = 1'b1;
      end
      last_nxt = ev_r.addr;
    end
  end

  // control and statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= 16'd0;
      corr_r      <= 16'd0;
      lo_page_r   <= PAGE_MAX;
      lo_off_r    <= OFFSET_MAX;
      hi_page_r   <= 20'd0;
      hi_off_r    <= 12'd0;
      mask_r      <= 32'd0;
      sum_r       <= 21'd0;
      fewest_r    <= BITS_RESET_MIN;
      most_r      <= 6'd0;
      run_r       <= 16'd1;
      max_run_r   <= 16'd0;
      last_r      <= 32'd0;
    end else begin
      if (!ev_valid_r || adv) begin
        ev_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= ev_valid_r;
      end
      if (fire) begin
        cnt_r      <= cnt_nxt;
        corr_r     <= corr_nxt;
        lo_page_r  <= lo_page_nxt;
        lo_off_r   <= lo_off_nxt;
        hi_page_r  <= hi_page_nxt;
        hi_off_r   <= hi_off_nxt;
        mask_r     <= mask_nxt;
        sum_r      <= sum_nxt;
        fewest_r   <= fewest_nxt;
        most_r     <= most_nxt;
        run_r      <= run_nxt;
        max_run_r  <= max_run_nxt;
        last_r     <= last_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ev_r <= prep;
    end
    if (fire) begin
      res_changed_r  <= changed_nxt;
      res_cnt_r      <= cnt_nxt;
      res_corr_r     <= corr_nxt;
      res_lo_page_r  <= lo_page_nxt;
      res_lo_off_r   <= lo_off_nxt;
      res_hi_page_r  <= hi_page_nxt;
      res_hi_off_r   <= hi_off_nxt;
      res_mask_r     <= mask_nxt;
      res_sum_r      <= sum_nxt;
      res_fewest_r   <= fewest_nxt;
      res_most_r     <= most_nxt;
      res_max_run_r  <= max_run_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_changed         = res_changed_r;
  assign out_total_errors    = res_cnt_r;
  assign out_corrected_count = res_corr_r;
  assign out_lowest_page     = res_lo_page_r;
  assign out_lowest_offset   = res_lo_off_r;
  assign out_highest_page    = res_hi_page_r;
  assign out_highest_offset  = res_hi_off_r;
  assign out_failing_mask    = res_mask_r;
  assign out_bits_total      = res_sum_r;
  assign out_fewest_bits     = res_fewest_r;
  assign out_most_bits       = res_most_r;
  assign out_longest_run     = res_max_run_r;

  // parity beats never report a change
  a_parity_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ev_r.kind == KIND_PARITY |=> !res_changed_r)
    else $error("parity event flagged a change");

  // failing mask only gains bits
  a_mask_grows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (mask_r & $past(mask_r)) == $past(mask_r))
    else $error("failing mask lost a bit");

  // event count never decreases and stays within limit
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> cnt_r >= $past(cnt_r) && cnt_r <= Limit)
    else $error("event count went backward or past limit");

  // after a non-parity event the longest run is at least one
  a_run_set: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ev_r.kind != KIND_PARITY |=> max_run_r != 16'd0 && max_run_r >= run_r)
    else $error("longest run not tracking current run");

  // result register takes a new value only when it is free or taken
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(res_cnt_r) && $stable(res_mask_r))
    else $error("result changed while stalled");

endmodule

// ===== verif/mes_checker.sv =====
// memory error statistics checker: watches both channels, predicts each result
// beat from the accepted events and compares field by field; depends on mes_pkg
module mes_checker
  import mes_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_word_address,
  input  logic [31:0] in_expected,
  input  logic [31:0] in_observed,
  input  logic [31:0] in_error_bits,
  input  logic [3:0]  in_test_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_changed,
  input  logic [15:0] out_total_errors,
  input  logic [15:0] out_corrected_count,
  input  logic [19:0] out_lowest_page,
  input  logic [11:0] out_lowest_offset,
  input  logic [19:0] out_highest_page,
  input  logic [11:0] out_highest_offset,
  input  logic [31:0] out_failing_mask,
  input  logic [20:0] out_bits_total,
  input  logic [5:0]  out_fewest_bits,
  input  logic [5:0]  out_most_bits,
  input  logic [15:0] out_longest_run,
  output int          mismatches,
  output int          pending,
  output int          results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ErrLimit  = DefErrorLimit;
  localparam logic [31:0] PatMask   = (DefDataWidth >= 32) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << DefDataWidth) - 64'd1);

  typedef struct {
    logic        changed;
    logic [15:0] total;
    logic [15:0] corrected;
    logic [19:0] low_page;
    logic [11:0] low_offset;
    logic [19:0] high_page;
    logic [11:0] high_offset;
    logic [31:0] mask;
    logic [20:0] bit_sum;
    logic [5:0]  fewest;
    logic [5:0]  most;
    logic [15:0] longest_run;
  } stats_t;

  stats_t expected_stats[$];
  stats_t want, next_stats;

  // running statistics as the block should hold them
  logic [15:0] event_count;
  logic [15:0] corr_count;
  logic [19:0] low_page, high_page;
  logic [11:0] low_offset, high_offset;
  logic [31:0] mask_acc;
  logic [20:0] bit_acc;
  logic [5:0]  fewest_seen, most_seen;
  logic [15:0] run_len, max_run;
  logic [31:0] prev_addr;

  task automatic fold_event(input kind_t k, input logic [31:0] addr, input logic [31:0] good,
                            input logic [31:0] bad, input logic [31:0] bits,
                            input logic [3:0] test, output stats_t r);
    logic [31:0] pat;
    logic [19:0] page;
    logic [11:0] offset;
    logic [5:0]  n;
    logic [21:0] sum;
    logic [31:0] step;
    logic        upd;
    upd = 1'b0;
    if (int'(event_count) < ErrLimit) event_count = event_count + 16'd1;
    if (k != KIND_PARITY) begin
      pat = (k == KIND_ADDR) ? (good ^ bad) : bits;
      pat = pat & PatMask;
      if (k == KIND_ECC) begin
        if (bad != 32'd0 && corr_count != CORR_MAX) corr_count = corr_count + 16'd1;
        page   = (addr > 32'(PAGE_MAX)) ? PAGE_MAX : addr[19:0];
        offset = (good > 32'(OFFSET_MAX)) ? OFFSET_MAX : good[11:0];
      end else begin
        page   = addr[31:12];
        offset = addr[11:0];
      end
      if (page < low_page) begin low_page = page; upd = 1'b1; end
      if (offset < low_offset) begin low_offset = offset; upd = 1'b1; end
      if (page > high_page) begin high_page = page; upd = 1'b1; end
      if (offset > high_offset) begin high_offset = offset; upd = 1'b1; end
      n = 6'($countones(pat));
      // bits only accumulate while the event count is still below its limit
      if (int'(event_count) < ErrLimit) begin
        sum = 22'(bit_acc) + 22'(n);
        bit_acc = (sum > 22'(SUM_MAX)) ? SUM_MAX : sum[20:0];
      end
      if (n > most_seen) begin most_seen = n; upd = 1'b1; end
      if (n < fewest_seen) begin fewest_seen = n; upd = 1'b1; end
      // any pattern unlike the old mask flags a change, new bits or not
      if ((mask_acc ^ pat) != 32'd0) upd = 1'b1;
      mask_acc = mask_acc | pat;
      step = (test == WIDE_STRIDE_TEST) ? 32'(STRIDE_WIDE) : 32'(STRIDE_NARROW);
      if (addr == prev_addr + step || addr == prev_addr - step) begin
        if (int'(run_len) < ErrLimit) run_len = run_len + 16'd1;
      end else begin
        run_len = 16'd1;
      end
      if (run_len > max_run) begin max_run = run_len; upd = 1'b1; end
      prev_addr = addr;
    end
    r.changed     = upd;
    r.total       = event_count;
    r.corrected   = corr_count;
    r.low_page    = low_page;
    r.low_offset  = low_offset;
    r.high_page   = high_page;
    r.high_offset = high_offset;
    r.mask        = mask_acc;
    r.bit_sum     = bit_acc;
    r.fewest      = fewest_seen;
    r.most        = most_seen;
    r.longest_run = max_run;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] got_val);
    if (got_val !== exp_val) begin
      mismatches++;
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      event_count = '0;
      corr_count  = '0;
      low_page    = PAGE_MAX;
      low_offset  = OFFSET_MAX;
      high_page   = '0;
      high_offset = '0;
      mask_acc    = '0;
      bit_acc     = '0;
      fewest_seen = BITS_RESET_MIN;
      most_seen   = '0;
      run_len     = 16'd1;
      max_run     = '0;
      prev_addr   = '0;
      expected_stats.delete();
    end else begin
      // result first: an event accepted on this edge cannot have its beat yet
      if (out_valid && !out_stall) begin
        if (expected_stats.size() == 0) begin
          mismatches++;
          $error("result beat with no event outstanding");
        end else begin
          want = expected_stats.pop_front();
          check_field("changed", 32'(want.changed), 32'(out_changed));
          check_field("total_errors", 32'(want.total), 32'(out_total_errors));
          check_field("corrected_count", 32'(want.corrected), 32'(out_corrected_count));
          check_field("lowest_page", 32'(want.low_page), 32'(out_lowest_page));
          check_field("lowest_offset", 32'(want.low_offset), 32'(out_lowest_offset));
          check_field("highest_page", 32'(want.high_page), 32'(out_highest_page));
          check_field("highest_offset", 32'(want.high_offset), 32'(out_highest_offset));
          check_field("failing_mask", want.mask, out_failing_mask);
          check_field("bits_total", 32'(want.bit_sum), 32'(out_bits_total));
          check_field("fewest_bits", 32'(want.fewest), 32'(out_fewest_bits));
          check_field("most_bits", 32'(want.most), 32'(out_most_bits));
          check_field("longest_run", 32'(want.longest_run), 32'(out_longest_run));
          results_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        fold_event(kind_t'(in_kind), in_word_address, in_expected, in_observed,
                   in_error_bits, in_test_index, next_stats);
        expected_stats.push_back(next_stats);
      end
    end
    pending = expected_stats.size();
  end

  initial begin
    mismatches      = 0;
    pending         = 0;
    results_checked = 0;
  end

endmodule

// ===== verif/tb_memory_error_statistics_unit.sv =====
// testbench top for memory_error_statistics_unit: clock, reset, event stimulus,
// result-side stall pattern and verdict; depends on mes_pkg and mes_checker
module tb_memory_error_statistics_unit
  import mes_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomEvents = 1400;
  localparam int SweepEvents  = 90;
  localparam int TailEvents   = 40;
  localparam int CycleLimit   = 1_500_000;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = '0;
  logic [31:0] in_word_address = '0;
  logic [31:0] in_expected = '0;
  logic [31:0] in_observed = '0;
  logic [31:0] in_error_bits = '0;
  logic [3:0]  in_test_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_changed;
  logic [15:0] out_total_errors;
  logic [15:0] out_corrected_count;
  logic [19:0] out_lowest_page;
  logic [11:0] out_lowest_offset;
  logic [19:0] out_highest_page;
  logic [11:0] out_highest_offset;
  logic [31:0] out_failing_mask;
  logic [20:0] out_bits_total;
  logic [5:0]  out_fewest_bits;
  logic [5:0]  out_most_bits;
  logic [15:0] out_longest_run;

  int mismatches, pending, results_checked;
  int cycle_count = 0;
  int burst_left = 0;
  bit long_bursts = 1'b0;
  int directed_sent = 0, random_sent = 0, sweep_sent = 0;
  logic [31:0] last_sent_addr = '0;
  stall_mode_t stall_mode = STALL_NONE;
  int mode_left = 0;

  memory_error_statistics_unit dut (.*);
  mes_checker checker_i (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: stall behavior switches among modes picked at random
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(32, 400);
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
      default:      out_stall <= ~out_stall;
    endcase
  end

  function automatic logic [31:0] random_pattern();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom;
      2, 3:    return 32'd1 << $urandom_range(0, 31);
      4:       return '0;
      5:       return '1;
      default: return $urandom & $urandom & $urandom;
    endcase
  endfunction

  task automatic send_event(input kind_t k, input logic [31:0] a, input logic [31:0] e,
                            input logic [31:0] o, input logic [31:0] b,
                            input logic [3:0] t);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      if (long_bursts && $urandom_range(0, 3) != 0) gap = 0;
      // idle cycles carry junk on the payload
      repeat (gap) begin
        @(negedge clk);
        in_valid        <= 1'b0;
        in_kind         <= 2'($urandom);
        in_word_address <= $urandom;
        in_error_bits   <= $urandom;
      end
      if (long_bursts) burst_left = $urandom_range(200, 2000);
      else if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(100, 300);
      else burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_valid        <= 1'b1;
    in_kind         <= k;
    in_word_address <= a;
    in_expected     <= e;
    in_observed     <= o;
    in_error_bits   <= b;
    in_test_index   <= t;
    do @(posedge clk); while (in_stall);
    if (k != KIND_PARITY) last_sent_addr = a;
  endtask

  task automatic send_random_event();
    kind_t       k;
    logic [31:0] a, e, o, step;
    logic [3:0]  t;
    int          pick;
    pick = $urandom_range(0, 99);
    k = (pick < 40) ? KIND_DATA : (pick < 60) ? KIND_ADDR : (pick < 85) ? KIND_ECC : KIND_PARITY;
    t = ($urandom_range(0, 2) == 0) ? WIDE_STRIDE_TEST : 4'($urandom);
    step = (t == WIDE_STRIDE_TEST) ? 32'(STRIDE_WIDE) : 32'(STRIDE_NARROW);
    pick = $urandom_range(0, 9);
    // half the events continue a run at the neighboring word
    if (pick < 5) a = $urandom_range(0, 1) ? last_sent_addr + step : last_sent_addr - step;
    else if (pick < 7) a = $urandom_range(0, 32'(PAGE_MAX));
    else a = $urandom;
    e = $urandom;
    o = $urandom;
    if (k == KIND_ECC) begin
      if ($urandom_range(0, 3) != 0) e = $urandom_range(0, 32'(OFFSET_MAX));
      if ($urandom_range(0, 1) == 0) o = '0;
    end
    if (k == KIND_ADDR && $urandom_range(0, 2) == 0) o = e ^ random_pattern();
    send_event(k, a, e, o, ($urandom_range(0, 3) == 0) ? 32'd0 : random_pattern(), t);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  initial begin
    logic [31:0] sweep_addr;
    logic [3:0]  t;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // page and offset extremes, zero and full patterns
    send_event(KIND_DATA, 32'h0000_0000, '0, '0, 32'h0000_0000, 4'd0);
    send_event(KIND_DATA, 32'hFFFF_FFFF, '0, '0, 32'hFFFF_FFFF, 4'd15);
    // address error: pattern rebuilt from expected and observed
    send_event(KIND_ADDR, 32'h0001_2345, 32'h0000_00F0, 32'h0000_0F00, 32'hFFFF_0000, 4'd1);
    // ecc with page and offset beyond range, then one not corrected
    send_event(KIND_ECC, 32'h1234_5678, 32'hFFFF_FFFF, 32'd1, 32'h0000_0003, 4'd2);
    send_event(KIND_ECC, 32'd5, 32'h0000_0800, 32'd0, 32'd0, 4'd3);
    send_event(KIND_PARITY, $urandom, $urandom, $urandom, $urandom, 4'd4);
    // pattern already inside the mask still counts as a change
    send_event(KIND_DATA, 32'h0000_0100, '0, '0, 32'h0000_0001, 4'd5);
    // runs up and down, and the wide stride of test 7
    send_event(KIND_DATA, 32'h0000_1000, '0, '0, 32'h0000_0010, 4'd3);
    send_event(KIND_DATA, 32'h0000_1004, '0, '0, 32'h0000_0010, 4'd3);
    send_event(KIND_DATA, 32'h0000_1008, '0, '0, 32'h0000_0010, 4'd3);
    send_event(KIND_DATA, 32'h0000_1004, '0, '0, 32'h0000_0010, 4'd3);
    send_event(KIND_DATA, 32'h0000_100C, '0, '0, 32'h0000_0010, WIDE_STRIDE_TEST);
    send_event(KIND_DATA, 32'h0000_1014, '0, '0, 32'h0000_0010, WIDE_STRIDE_TEST);
    send_event(KIND_DATA, 32'h0000_1018, '0, '0, 32'h0000_0010, WIDE_STRIDE_TEST);
    // run across the top of the address space
    send_event(KIND_DATA, 32'hFFFF_FFFC, '0, '0, 32'h0000_0002, 4'd0);
    send_event(KIND_DATA, 32'h0000_0000, '0, '0, 32'h0000_0002, 4'd0);
    send_event(KIND_DATA, 32'hFFFF_FFFC, '0, '0, 32'h0000_0002, 4'd0);
    send_event(KIND_DATA, 32'h0000_0004, '0, '0, 32'h0000_0002, WIDE_STRIDE_TEST);
    send_event(KIND_ECC, 32'(PAGE_MAX), 32'(OFFSET_MAX), 32'hFFFF_FFFF, 32'd0, 4'd6);
    // a parity beat inside a run leaves the last address alone
    send_event(KIND_DATA, 32'h0000_0008, '0, '0, 32'h0000_0004, 4'd0);
    send_event(KIND_PARITY, 32'h0000_0999, $urandom, $urandom, $urandom, 4'd0);
    send_event(KIND_DATA, 32'h0000_000C, '0, '0, 32'h0000_0004, 4'd0);
    directed_sent = 22;

    for (int i = 0; i < RandomEvents; i++) begin
      if (i == RandomEvents / 2) wait_idle();
      send_random_event();
      random_sent++;
    end
    wait_idle();

    // long adjacent ecc sweep builds a long run in dense bursts
    long_bursts = 1'b1;
    sweep_addr = 32'h0004_0000;
    for (int i = 0; i < SweepEvents; i++) begin
      if (i % 32 == 31) begin
        send_event(KIND_PARITY, $urandom, $urandom, $urandom, $urandom, 4'($urandom));
      end else begin
        t = 4'($urandom);
        if (t == WIDE_STRIDE_TEST) t = 4'd0;
        send_event(KIND_ECC, sweep_addr, $urandom_range(0, 32'(OFFSET_MAX)),
                   $urandom | 32'd1, random_pattern(), t);
        sweep_addr = sweep_addr + 32'(STRIDE_NARROW);
      end
      sweep_sent++;
    end
    long_bursts = 1'b0;
    for (int i = 0; i < TailEvents; i++) begin
      send_random_event();
      random_sent++;
    end
    wait_idle();

    $display("run covered %0d directed, %0d random and %0d adjacent-sweep events",
             directed_sent, random_sent, sweep_sent);
    $display("%0d result beats compared, %0d field mismatches", results_checked, mismatches);
    if (mismatches == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
